/* hw/rtl/dvb_pkg.sv */
// Shared constants, field layout and sequencer states of the damped voice bank resampler.
`default_nettype none

package dvb_pkg;

    // Field widths and fixed-point formats.
    localparam int KIND_W     = 1;
    localparam int IDX_W      = 6;
    localparam int COEF_W     = 32;
    localparam int SAMPLE_W   = 32;
    localparam int RATE_W     = 28;
    localparam int SUM_W      = 40;
    localparam int CFG_W      = 7;
    localparam int COEF_FRAC  = 30;
    localparam int PHASE_FRAC = 24;
    localparam int CROSS_W    = RATE_W + 1 - PHASE_FRAC;

    // Default number of voice slots.
    localparam int VOICE_SLOTS_DEF = 64;

    // Shared multiplier: signed operands wide enough for a signed 32-bit value
    // or an unsigned 24-bit value.
    localparam int MUL_W  = COEF_W + 1;
    localparam int PROD_W = 2 * MUL_W;

    // Input tdata layout, lowest field first.
    localparam int OFS_IDX   = 0;
    localparam int OFS_A1    = OFS_IDX + IDX_W;
    localparam int OFS_A2    = OFS_A1 + COEF_W;
    localparam int OFS_NOW   = OFS_A2 + COEF_W;
    localparam int OFS_PREV  = OFS_NOW + COEF_W;
    localparam int OFS_RATE  = OFS_PREV + COEF_W;
    localparam int IN_BITS   = OFS_RATE + RATE_W;
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SUM_W + 7) / 8) * 8;

    // Item kinds carried in tuser.
    localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
    localparam logic [KIND_W-1:0] KIND_STEP = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP_BEGIN,
        ST_READ,
        ST_MUL1,
        ST_MUL2,
        ST_WB,
        ST_STEP_END,
        ST_INT1,
        ST_INT2,
        ST_DONE
    } dvb_state_t;

endpackage

`default_nettype wire

/* hw/rtl/dvb_mul.sv */
// Shared registered signed multiplier used by the voice recursion and the interpolator.
`default_nettype none

module dvb_mul
    import dvb_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     mul_en,
    input  wire logic signed [MUL_W-1:0]  op_a,
    input  wire logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0]      prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* hw/rtl/damped_voice_bank_resampler_core.sv */
// Top level of the damped voice bank resampler: voice memory, sequencer and interpolator.
//
// Usage:
// Items arrive on the s_ stream. s_tuser carries the kind. A load item writes one
// voice slot (two Q2.30 coefficients and two Q2.30 history samples) and yields no
// result; s_tready stays high, so another item can be taken in the next cycle.
// A step item adds its Q4.24 rate to the fractional phase. For each whole unit
// crossed, every active voice advances once and a new voice sum is formed; the
// result is the sum interpolated at the phase, given as one item on the m_ stream.
// The user must write the number of active voices over the cfg_ channel only while
// idle; the block does not enforce this. While a step item is processed s_tready is
// low. It returns, and m_tvalid rises in the same cycle, once the output register is
// free. Each voice takes two products on the single shared multiplier and one memory
// write-back.
// A pending result waits in the output register while the next item is accepted;
// a finished result is held back until the receiver takes the pending one.
// Reset clears the phase, both sums, the voice count and the output valid flag.
// Voice slots are not cleared and must be loaded before they are made active.
`default_nettype none

module damped_voice_bank_resampler_core
    import dvb_pkg::*;
#(
    parameter int VOICE_SLOTS = VOICE_SLOTS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // Fields from bit 0: voice_index, load_a1, load_a2, load_now, load_prev, rate.
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: kind.
    input  wire logic [KIND_W-1:0]     s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // Fields from bit 0: sample.
    output logic [M_TDATA_W-1:0]       m_tdata,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    localparam int IW      = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
    localparam int CW      = $clog2(VOICE_SLOTS + 1);
    localparam int ACC_W   = (SAMPLE_W + CW > SUM_W + 1) ? SAMPLE_W + CW : SUM_W + 1;
    localparam int ENTRY_W = 2 * COEF_W + 2 * SAMPLE_W;
    localparam int DIFF_W  = PROD_W + 1;
    localparam int SHR_W   = DIFF_W - COEF_FRAC;
    localparam int D_W     = SUM_W + 1;
    localparam int DH_W    = D_W - PHASE_FRAC;
    localparam int Y_W     = SUM_W + 2;

    typedef struct packed {
        logic                     mul_en;
        logic signed [MUL_W-1:0]  mul_a;
        logic signed [MUL_W-1:0]  mul_b;
        logic                     hold_en;
        logic                     rd_en;
        logic [IW-1:0]            rd_addr;
        logic                     wr_en;
        logic [IW-1:0]            wr_addr;
        logic [ENTRY_W-1:0]       wr_data;
    } ctl_t;

    dvb_state_t state_reg, state_next;
    ctl_t       ctl;

    logic [CFG_W-1:0]          cfg_count_reg;
    logic [PHASE_FRAC-1:0]     frac_reg;
    logic signed [SUM_W-1:0]   sum_older_reg;
    logic signed [SUM_W-1:0]   sum_newer_reg;
    logic [CROSS_W-1:0]        cross_reg;
    logic [CW-1:0]             ctr_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [ENTRY_W-1:0]        rd_reg;
    logic signed [PROD_W-1:0]  hold_reg;
    logic                      out_valid_reg;
    logic [SUM_W-1:0]          out_data_reg;

    logic [ENTRY_W-1:0] mem [VOICE_SLOTS];

    // Input fields.
    logic [IDX_W-1:0]    in_idx;
    logic [COEF_W-1:0]   in_a1;
    logic [COEF_W-1:0]   in_a2;
    logic [SAMPLE_W-1:0] in_now;
    logic [SAMPLE_W-1:0] in_prev;
    logic [RATE_W-1:0]   in_rate;
    logic                in_accept;
    logic                in_step;

    logic [RATE_W:0]     total;
    logic [CW-1:0]       n_eff;
    logic [CW-1:0]       ctr_inc;
    logic                more;
    logic                out_free;

    // Fields of the registered voice entry.
    logic signed [COEF_W-1:0]   rd_a1;
    logic signed [COEF_W-1:0]   rd_a2;
    logic signed [SAMPLE_W-1:0] rd_now;
    logic signed [SAMPLE_W-1:0] rd_prev;

    logic signed [PROD_W-1:0]   mul_prod;
    logic signed [DIFF_W-1:0]   diff;
    logic [SHR_W-1:0]           diff_shr;
    logic [SAMPLE_W-1:0]        new_now;
    logic [SUM_W-1:0]           acc_sat;
    logic signed [D_W-1:0]      d;
    logic [PHASE_FRAC-1:0]      dl;
    logic signed [DH_W-1:0]     dh;
    logic [Y_W-1:0]             y;

    assign in_idx  = s_tdata[OFS_IDX +: IDX_W];
    assign in_a1   = s_tdata[OFS_A1 +: COEF_W];
    assign in_a2   = s_tdata[OFS_A2 +: COEF_W];
    assign in_now  = s_tdata[OFS_NOW +: SAMPLE_W];
    assign in_prev = s_tdata[OFS_PREV +: SAMPLE_W];
    assign in_rate = s_tdata[OFS_RATE +: RATE_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_step   = (s_tuser == KIND_STEP);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = M_TDATA_W'(out_data_reg);
    assign out_free  = !out_valid_reg || m_tready;

    assign total   = (RATE_W + 1)'(frac_reg) + (RATE_W + 1)'(in_rate);
    assign ctr_inc = ctr_reg + CW'(1);
    assign more    = (ctr_inc < n_eff);

    always_comb begin
        if (32'(cfg_count_reg) > VOICE_SLOTS) begin
            n_eff = CW'(VOICE_SLOTS);
        end else begin
            n_eff = CW'(cfg_count_reg);
        end
    end

    assign rd_a1   = rd_reg[ENTRY_W-1 -: COEF_W];
    assign rd_a2   = rd_reg[ENTRY_W-COEF_W-1 -: COEF_W];
    assign rd_now  = rd_reg[2*SAMPLE_W-1 -: SAMPLE_W];
    assign rd_prev = rd_reg[SAMPLE_W-1:0];

    // Recursion: floor((a1*now - a2*prev) / 2^30), saturated to the sample width.
    assign diff     = DIFF_W'(hold_reg) - DIFF_W'(mul_prod);
    assign diff_shr = diff[DIFF_W-1:COEF_FRAC];
    always_comb begin
        if ((&diff_shr[SHR_W-1:SAMPLE_W-1]) || !(|diff_shr[SHR_W-1:SAMPLE_W-1])) begin
            new_now = diff_shr[SAMPLE_W-1:0];
        end else begin
            new_now = {diff_shr[SHR_W-1], {(SAMPLE_W - 1){~diff_shr[SHR_W-1]}}};
        end
    end

    always_comb begin
        if ((&acc_reg[ACC_W-1:SUM_W-1]) || !(|acc_reg[ACC_W-1:SUM_W-1])) begin
            acc_sat = acc_reg[SUM_W-1:0];
        end else begin
            acc_sat = {acc_reg[ACC_W-1], {(SUM_W - 1){~acc_reg[ACC_W-1]}}};
        end
    end

    // Interpolation splits the difference so each product fits the multiplier.
    assign d  = D_W'(sum_newer_reg) - D_W'(sum_older_reg);
    assign dl = d[PHASE_FRAC-1:0];
    assign dh = d[D_W-1:PHASE_FRAC];
    assign y  = Y_W'(sum_older_reg) + Y_W'(mul_prod)
              + Y_W'(hold_reg[2*PHASE_FRAC-1:PHASE_FRAC]);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && in_step) begin
                    if (total[RATE_W:PHASE_FRAC] == '0) begin
                        state_next = ST_INT1;
                    end else begin
                        state_next = ST_STEP_BEGIN;
                    end
                end
            end
            ST_STEP_BEGIN: begin
                state_next = (n_eff == '0) ? ST_STEP_END : ST_READ;
            end
            ST_READ: begin
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                state_next = ST_WB;
            end
            ST_WB: begin
                state_next = more ? ST_MUL1 : ST_STEP_END;
            end
            ST_STEP_END: begin
                state_next = (cross_reg == CROSS_W'(1)) ? ST_INT1 : ST_STEP_BEGIN;
            end
            ST_INT1: begin
                state_next = ST_INT2;
            end
            ST_INT2: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath controls.
    always_comb begin
        ctl = '0;
        case (state_reg)
            ST_IDLE: begin
                ctl.wr_en   = in_accept && !in_step && (32'(in_idx) < VOICE_SLOTS);
                ctl.wr_addr = IW'(in_idx);
                ctl.wr_data = {in_a1, in_a2, in_now, in_prev};
            end
            ST_READ: begin
                ctl.rd_en   = 1'b1;
                ctl.rd_addr = ctr_reg[IW-1:0];
            end
            ST_MUL1: begin
                ctl.mul_en = 1'b1;
                ctl.mul_a  = MUL_W'(rd_a1);
                ctl.mul_b  = MUL_W'(rd_now);
            end
            ST_MUL2: begin
                ctl.mul_en  = 1'b1;
                ctl.hold_en = 1'b1;
                ctl.mul_a   = MUL_W'(rd_a2);
                ctl.mul_b   = MUL_W'(rd_prev);
            end
            ST_WB: begin
                // Write this voice back and fetch the next one in the same cycle.
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = ctr_reg[IW-1:0];
                ctl.wr_data = {rd_a1, rd_a2, new_now, rd_now};
                ctl.rd_en   = more;
                ctl.rd_addr = ctr_inc[IW-1:0];
            end
            ST_INT1: begin
                ctl.mul_en = 1'b1;
                ctl.mul_a  = MUL_W'(dl);
                ctl.mul_b  = MUL_W'(frac_reg);
            end
            ST_INT2: begin
                ctl.mul_en  = 1'b1;
                ctl.hold_en = 1'b1;
                ctl.mul_a   = MUL_W'(dh);
                ctl.mul_b   = MUL_W'(frac_reg);
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

    dvb_mul u_mul (
        .aclk   (aclk),
        .mul_en (ctl.mul_en),
        .op_a   (ctl.mul_a),
        .op_b   (ctl.mul_b),
        .prod   (mul_prod)
    );

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        if (ctl.rd_en) begin
            rd_reg <= mem[ctl.rd_addr];
        end
        if (ctl.hold_en) begin
            hold_reg <= mul_prod;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cfg_count_reg <= '0;
            frac_reg      <= '0;
            sum_older_reg <= '0;
            sum_newer_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                cfg_count_reg <= cfg_data;
            end
            if ((state_reg == ST_DONE) && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_accept && in_step) begin
                        frac_reg  <= total[PHASE_FRAC-1:0];
                        cross_reg <= total[RATE_W:PHASE_FRAC];
                    end
                end
                ST_STEP_BEGIN: begin
                    sum_older_reg <= sum_newer_reg;
                    acc_reg       <= '0;
                    ctr_reg       <= '0;
                end
                ST_WB: begin
                    acc_reg <= acc_reg + ACC_W'(rd_now);
                    ctr_reg <= ctr_inc;
                end
                ST_STEP_END: begin
                    sum_newer_reg <= acc_sat;
                    cross_reg     <= cross_reg - CROSS_W'(1);
                end
                ST_DONE: begin
                    if (out_free) begin
                        out_data_reg <= y[SUM_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/dvb_checker.sv */
// Port-level assertions for the damped voice bank resampler, bound to its top level.
`default_nettype none

module dvb_checker
    import dvb_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [KIND_W-1:0]     s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A step item keeps the block busy for at least the following cycle.
    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == KIND_STEP) |=> !s_tready)
        else $error("block ready right after a step item");

    // A load item leaves the block ready in the next cycle.
    a_load_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == KIND_LOAD) |=> s_tready)
        else $error("block busy after a load item");

endmodule

bind damped_voice_bank_resampler_core dvb_checker u_dvb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
